[rtl/mow_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mow_pkg
// Shared constants, types and the sine table for the wheel odometry block.
// ----------------------------------------------------------------------------
package mow_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_ENTRIES    = 1 << SINE_TABLE_BITS;

  localparam logic REG_METRES_PER_TICK   = 1'b0;
  localparam logic REG_INVERSE_HALF_BASE = 1'b1;

  localparam logic [17:0] IHB_RESET = 18'd94196;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef logic signed [31:0] sine_rom_t [SINE_ENTRIES];

  typedef struct packed {
    logic       en;
    logic       clr;
    logic       sub;
    logic [4:0] sh;
  } mow_mac_op_t;

  function automatic sine_rom_t make_sine_rom();
    sine_rom_t         rom;
    longint unsigned   u, x, x2, t, s;
    logic [31:0]       ph;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      ph = 32'(i) << (32 - SINE_TABLE_BITS);
      u  = {34'd0, ph[29:0]};
      if (ph[30]) u = Q30_ONE - u;
      x  = (u * PI_HALF_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      rom[i] = ph[31] ? -(32'(s)) : 32'(s);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = make_sine_rom();

endpackage
`default_nettype wire

[rtl/mow_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mow_sine_rom
// Full-turn Q30 sine table with registered read.
// ----------------------------------------------------------------------------
module mow_sine_rom import mow_pkg::*; (
  input  wire logic                       clk,
  input  wire logic [SINE_TABLE_BITS-1:0] addr,
  output logic signed [31:0]              data_r
);

  always_ff @(posedge clk) begin
    data_r <= SINE_ROM[addr];
  end

endmodule
`default_nettype wire

[rtl/mow_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mow_mac
// Shared multiply-accumulate unit: registered 37x19 product, then shifted
// add or subtract into a 72-bit accumulator.
// ----------------------------------------------------------------------------
module mow_mac import mow_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mow_mac_op_t        op,
  input  wire logic signed [36:0] a,
  input  wire logic signed [18:0] b,
  output logic signed [71:0]      acc_r
);

  mow_mac_op_t        op_r;
  logic signed [55:0] p_r;
  logic signed [71:0] term;
  logic signed [71:0] base;
  logic signed [71:0] acc_nxt;

  always_comb begin
    term    = {{16{p_r[55]}}, p_r} <<< op_r.sh;
    base    = op_r.clr ? '0 : acc_r;
    acc_nxt = op_r.sub ? base - term : base + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= '0;
    end else begin
      op_r <= op;
    end
    p_r <= a * b;
    if (op_r.en) acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire

[rtl/mow_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mow_div
// Radix-2 restoring divider, 54-bit dividend by 16-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module mow_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [53:0] num,
  input  wire logic [15:0] den,
  output logic             done_r,
  output logic [53:0]      quo_r
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [15:0] rem_r;
  logic [15:0] den_r;
  logic [16:0] rem_sh;
  logic [17:0] trial;

  always_comb begin
    rem_sh = {rem_r, quo_r[53]};
    trial  = {1'b0, rem_sh} - {2'b00, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd53) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_r <= trial[15:0];
        quo_r <= {quo_r[52:0], 1'b1};
      end else begin
        rem_r <= rem_sh[15:0];
        quo_r <= {quo_r[52:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

[rtl/mecanum_wheel_odometry.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mecanum_wheel_odometry
// Mecanum dead reckoning: wheel count deltas to body deltas, heading-rotated
// pose integration and velocities, sequenced over one shared MAC unit, a
// sine ROM and a bit-serial divider.
//
//   channel  dir  width  content
//   in_      in   144    wheel0..3 counts, period_us
//   out_     out  192    pose_x, pose_y, heading, speed_x, speed_y, yaw_rate
//   cfg_     in   1+32   register index, write data
//
// One beat runs through 36 sequencer steps and three divider waits; the
// divider loop sets most of its length. in_tready is high only while idle.
// The result sits in an output register, so the next beat may be taken while
// it waits; the sequencer stalls at its last step only when a new result is
// ready and the previous one is still held. Reset is synchronous and clears
// pose, heading and stored counts, zeroes the metres-per-tick register and
// sets the inverse half-base register to its default.
// ----------------------------------------------------------------------------
module mecanum_wheel_odometry import mow_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,   // wheel0, wheel1, wheel2, wheel3, period_us
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [191:0]      out_tdata,  // pose_x, pose_y, heading, speed_x, speed_y, yaw_rate
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [5:0] P_SX_HI = 6'd0,  P_SX_LO = 6'd1,  P_SY_HI = 6'd2;
  localparam logic [5:0] P_SY_LO = 6'd3,  P_SA_HI = 6'd4,  P_SA_LO = 6'd5;
  localparam logic [5:0] P_SA_W  = 6'd6,  P_ARC   = 6'd7,  P_TH    = 6'd8;
  localparam logic [5:0] P_TH_W  = 6'd9,  P_R     = 6'd10, P_HB_HI = 6'd11;
  localparam logic [5:0] P_HB_LO = 6'd12, P_GX0   = 6'd13, P_GX1   = 6'd14;
  localparam logic [5:0] P_GX2   = 6'd15, P_GX3   = 6'd16, P_GY0   = 6'd17;
  localparam logic [5:0] P_GY1   = 6'd18, P_GY2   = 6'd19, P_GY3   = 6'd20;
  localparam logic [5:0] P_GY_W  = 6'd21, P_GY    = 6'd22, P_VX_HI = 6'd23;
  localparam logic [5:0] P_VX_LO = 6'd24, P_VX_W  = 6'd25, P_VX_GO = 6'd26;
  localparam logic [5:0] P_VX    = 6'd27, P_VY_HI = 6'd28, P_VY_LO = 6'd29;
  localparam logic [5:0] P_VY_W  = 6'd30, P_VY_GO = 6'd31, P_VY    = 6'd32;
  localparam logic [5:0] P_VR_HI = 6'd33, P_VR_LO = 6'd34, P_VR_W  = 6'd35;
  localparam logic [5:0] P_VR_GO = 6'd36, P_VR    = 6'd37, P_OUT   = 6'd38;

  localparam logic signed [18:0] K_HI   = 19'sd20860;
  localparam logic signed [18:0] K_LO   = 19'sd24796;
  localparam logic signed [18:0] MEG_HI = 19'sd15;
  localparam logic signed [18:0] MEG_LO = 19'sd16960;
  localparam logic [SINE_TABLE_BITS-1:0] QUARTER = SINE_TABLE_BITS'(SINE_ENTRIES / 4);

  function automatic logic [31:0] sat32(logic signed [53:0] v);
    if (v > 54'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -54'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  logic               st_r, st_nxt;
  logic [5:0]         step_r, step_nxt;
  logic [31:0]        mpt_r;
  logic [17:0]        ihb_r;
  logic [31:0]        prev_r [4];
  logic               first_r;
  logic signed [35:0] nsx_r, nsy_r, nsa_r;
  logic [15:0]        period_r;
  logic signed [31:0] dx_r, dy_r, arc_r, sin_r, cos_r;
  logic signed [33:0] r_r;
  logic signed [47:0] posx_r, posy_r;
  logic [31:0]        head_r, spx_r, spy_r;
  logic               neg_r;
  logic               out_tvalid_r;
  logic [191:0]       out_tdata_r;

  logic signed [31:0] d [4];
  logic               accept, load_out;
  mow_mac_op_t        op;
  logic signed [36:0] ma;
  logic signed [18:0] mb;
  logic signed [71:0] acc;
  logic [SINE_TABLE_BITS-1:0] rom_addr, sin_idx;
  logic signed [31:0] rom_data;
  logic               div_start, div_done;
  logic [53:0]        div_quo, div_num;
  logic signed [71:0] acc_mag;
  logic [31:0]        vel;
  logic signed [49:0] pos_sum;
  logic signed [47:0] pos_sat;
  logic signed [47:0] pos_sel;

  mow_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .a     (ma),
    .b     (mb),
    .acc_r (acc)
  );

  mow_sine_rom u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  mow_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (period_r),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign sin_idx    = head_r[31 -: SINE_TABLE_BITS];
  assign rom_addr   = (step_r == P_SX_HI) ? sin_idx : sin_idx + QUARTER;
  assign load_out   = (st_r == ST_RUN) && (step_r == P_OUT) &&
                      (!out_tvalid_r || out_tready);
  assign div_start  = (st_r == ST_RUN) &&
                      (step_r == P_VX_GO || step_r == P_VY_GO || step_r == P_VR_GO);
  assign acc_mag    = acc[71] ? -acc : acc;
  assign div_num    = acc_mag[53:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d[i] = first_r ? 32'sd0 : $signed(in_tdata[32*i +: 32] - prev_r[i]);
    end
  end

  always_comb begin
    if (period_r == 16'd0) begin
      vel = '0;
    end else if (!neg_r) begin
      vel = (|div_quo[53:31]) ? 32'h7FFFFFFF : {1'b0, div_quo[30:0]};
    end else begin
      vel = (div_quo > 54'h80000000) ? 32'h80000000 : -div_quo[31:0];
    end
  end

  always_comb begin
    pos_sel = (step_r == P_GY1) ? posx_r : posy_r;
    pos_sum = {{2{pos_sel[47]}}, pos_sel} + {{8{acc[71]}}, acc[71:30]};
    if (pos_sum > 50'sh7FFFFFFFFFFF) pos_sat = 48'sh7FFFFFFFFFFF;
    else if (pos_sum < -50'sh800000000000) pos_sat = 48'sh800000000000;
    else pos_sat = pos_sum[47:0];
  end

  always_comb begin
    op = '0;
    ma = '0;
    mb = '0;
    if (st_r == ST_RUN) begin
      case (step_r)
        P_SX_HI: begin ma = 37'(nsx_r); mb = {3'b0, mpt_r[31:16]}; op = '{1, 1, 0, 16}; end
        P_SX_LO: begin ma = 37'(nsx_r); mb = {3'b0, mpt_r[15:0]};  op = '{1, 0, 0, 0};  end
        P_SY_HI: begin ma = 37'(nsy_r); mb = {3'b0, mpt_r[31:16]}; op = '{1, 1, 0, 16}; end
        P_SY_LO: begin ma = 37'(nsy_r); mb = {3'b0, mpt_r[15:0]};  op = '{1, 0, 0, 0};  end
        P_SA_HI: begin ma = 37'(nsa_r); mb = {3'b0, mpt_r[31:16]}; op = '{1, 1, 0, 16}; end
        P_SA_LO: begin ma = 37'(nsa_r); mb = {3'b0, mpt_r[15:0]};  op = '{1, 0, 0, 0};  end
        P_TH:    begin ma = 37'(arc_r); mb = {1'b0, ihb_r};        op = '{1, 1, 0, 0};  end
        P_HB_HI: begin ma = 37'(r_r);   mb = K_HI;                 op = '{1, 1, 0, 15}; end
        P_HB_LO: begin ma = 37'(r_r);   mb = K_LO;                 op = '{1, 0, 0, 0};  end
        P_GX0:   begin ma = 37'(dx_r);  mb = 19'($signed(cos_r[31:16])); op = '{1, 1, 0, 16}; end
        P_GX1:   begin ma = 37'(dx_r);  mb = {3'b0, cos_r[15:0]};  op = '{1, 0, 0, 0};  end
        P_GX2:   begin ma = 37'(dy_r);  mb = 19'($signed(sin_r[31:16])); op = '{1, 0, 1, 16}; end
        P_GX3:   begin ma = 37'(dy_r);  mb = {3'b0, sin_r[15:0]};  op = '{1, 0, 1, 0};  end
        P_GY0:   begin ma = 37'(dx_r);  mb = 19'($signed(sin_r[31:16])); op = '{1, 1, 0, 16}; end
        P_GY1:   begin ma = 37'(dx_r);  mb = {3'b0, sin_r[15:0]};  op = '{1, 0, 0, 0};  end
        P_GY2:   begin ma = 37'(dy_r);  mb = 19'($signed(cos_r[31:16])); op = '{1, 0, 0, 16}; end
        P_GY3:   begin ma = 37'(dy_r);  mb = {3'b0, cos_r[15:0]};  op = '{1, 0, 0, 0};  end
        P_VX_HI: begin ma = 37'(dx_r);  mb = MEG_HI;               op = '{1, 1, 0, 16}; end
        P_VX_LO: begin ma = 37'(dx_r);  mb = MEG_LO;               op = '{1, 0, 0, 0};  end
        P_VY_HI: begin ma = 37'(dy_r);  mb = MEG_HI;               op = '{1, 1, 0, 16}; end
        P_VY_LO: begin ma = 37'(dy_r);  mb = MEG_LO;               op = '{1, 0, 0, 0};  end
        P_VR_HI: begin ma = 37'(r_r);   mb = MEG_HI;               op = '{1, 1, 0, 16}; end
        P_VR_LO: begin ma = 37'(r_r);   mb = MEG_LO;               op = '{1, 0, 0, 0};  end
        default: begin op = '0; end
      endcase
    end
  end

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    if (st_r == ST_IDLE) begin
      if (accept) begin
        st_nxt   = ST_RUN;
        step_nxt = P_SX_HI;
      end
    end else begin
      case (step_r)
        P_VX, P_VY, P_VR: begin
          if (div_done) step_nxt = step_r + 6'd1;
        end
        P_OUT: begin
          if (load_out) begin
            st_nxt   = ST_IDLE;
            step_nxt = P_SX_HI;
          end
        end
        default: begin
          step_nxt = step_r + 6'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      step_r       <= P_SX_HI;
      mpt_r        <= '0;
      ihb_r        <= IHB_RESET;
      first_r      <= 1'b1;
      for (int i = 0; i < 4; i++) prev_r[i] <= '0;
      posx_r       <= '0;
      posy_r       <= '0;
      head_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_METRES_PER_TICK:   mpt_r <= cfg_wdata;
          REG_INVERSE_HALF_BASE: ihb_r <= cfg_wdata[17:0];
          default: ;
        endcase
      end
      if (accept) begin
        first_r <= 1'b0;
        for (int i = 0; i < 4; i++) prev_r[i] <= in_tdata[32*i +: 32];
      end
      if (st_r == ST_RUN) begin
        case (step_r)
          P_GX1: head_r <= head_r + acc[47:16];
          P_GY1: posx_r <= pos_sat;
          P_GY:  posy_r <= pos_sat;
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      if (load_out) out_tvalid_r <= 1'b1;
    end

    if (accept) begin
      nsx_r    <= -36'(d[0]) + 36'(d[1]) - 36'(d[2]) + 36'(d[3]);
      nsy_r    <= 36'(d[0]) + 36'(d[1]) - 36'(d[2]) - 36'(d[3]);
      nsa_r    <= -(36'(d[0]) + 36'(d[1]) + 36'(d[2]) + 36'(d[3]));
      period_r <= in_tdata[143:128];
    end
    if (st_r == ST_RUN) begin
      case (step_r)
        P_SX_LO: sin_r <= rom_data;
        P_SY_HI: cos_r <= rom_data;
        P_SY_LO: dx_r  <= $signed(sat32($signed(acc[71:18])));
        P_SA_LO: dy_r  <= $signed(sat32($signed(acc[71:18])));
        P_ARC:   arc_r <= $signed(sat32($signed(acc[71:18])));
        P_R:     r_r   <= acc[49:16];
        P_VX:    spx_r <= vel;
        P_VY:    spy_r <= vel;
        default: ;
      endcase
    end
    if (div_start) neg_r <= acc[71];
    if (load_out) begin
      out_tdata_r <= {vel, spy_r, spx_r, head_r,
                      sat32(54'(posy_r)), sat32(54'(posx_r))};
    end
  end

  ast_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready && step_r == P_SX_HI)
    else $error("sequencer did not start on accepted beat");

  ast_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(step_r) == P_OUT)
    else $error("result loaded outside the output step");

  ast_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == ST_RUN &&
      (step_r == P_VX || step_r == P_VY || step_r == P_VR))
    else $error("divider finished while sequencer not waiting");

endmodule
`default_nettype wire
